@@ rtl/core/lrn_pkg.sv @@
// Package for the cross-channel LRN unit: payload and job types, FSM state
// types, register codes and the table of square roots used by the exp2 stage.
// No dependencies.
`timescale 1ns / 1ps

package lrn_pkg;

  localparam int unsigned MaxWindowDefault = 15;
  localparam int unsigned SampleDepth      = 8;
  localparam int unsigned SumW             = 36;
  localparam int unsigned RootW            = 30;
  localparam int unsigned RootCount        = 16;

  typedef struct packed {
    logic signed [15:0] sample;
    logic               last_channel;
  } lrn_in_t;

  typedef struct packed {
    logic signed [15:0] normalized;
    logic               last_of_pixel;
  } lrn_out_t;

  // one normalisation to carry out: the sample, its window sum and the end flag
  typedef struct packed {
    logic signed [15:0] sample;
    logic [SumW-1:0]    sum;
    logic               last;
  } lrn_job_t;

  typedef enum logic [1:0] {
    CFG_WINDOW = 2'd0,
    CFG_ALPHA  = 2'd1,
    CFG_BETA   = 2'd2
  } lrn_cfg_e;

  typedef enum logic [1:0] {
    F_IDLE,
    F_SUM,
    F_EMIT
  } lrn_front_e;

  typedef enum logic [3:0] {
    B_IDLE,
    B_ZLO,
    B_ZHI,
    B_NORM,
    B_LOG,
    B_TMUL,
    B_EXP,
    B_YMUL,
    B_OUT
  } lrn_back_e;

  function automatic logic [63:0] isqrt64(logic [63:0] v);
    logic [63:0] res;
    logic [63:0] bt;
    logic [63:0] rem;
    res = '0;
    bt  = 64'd1 << 62;
    rem = v;
    for (int s = 0; s < 32; s++) begin
      if (bt > rem) bt = bt >> 2;
    end
    for (int s = 0; s < 32; s++) begin
      if (bt != 0) begin
        if (rem >= res + bt) begin
          rem = rem - (res + bt);
          res = (res >> 1) + bt;
        end else begin
          res = res >> 1;
        end
        bt = bt >> 2;
      end
    end
    return res;
  endfunction

  // r(1) = sqrt(0.5), r(k+1) = sqrt(r(k)), Q0.30, each truncated
  function automatic logic [RootCount*RootW-1:0] exp_roots();
    logic [RootCount*RootW-1:0] tab;
    logic [63:0]                r;
    tab = '0;
    r   = 64'd1 << 29;
    for (int j = 0; j < RootCount; j++) begin
      r = isqrt64(r << 30);
      tab[j*RootW +: RootW] = r[RootW-1:0];
    end
    return tab;
  endfunction

  localparam logic [RootCount*RootW-1:0] ExpRoots = exp_roots();

endpackage

@@ rtl/core/lrn_fifo.sv @@
// Small register queue, used between front and back and at the result side.
// No dependencies.
`timescale 1ns / 1ps

module lrn_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  output logic             full_o,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             pop_i,
  output logic             empty_o,
  output logic [WIDTH-1:0] rdata_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [AW-1:0]    wp_q, rp_q;
  logic [CW-1:0]    cnt_q;
  logic             wr, rd;

  assign full_o  = cnt_q == CW'(DEPTH);
  assign empty_o = cnt_q == '0;
  assign wr      = push_i && !full_o;
  assign rd      = pop_i && !empty_o;
  assign rdata_o = mem_q[rp_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (wr) wp_q <= (wp_q == AW'(DEPTH - 1)) ? '0 : wp_q + 1'b1;
      if (rd) rp_q <= (rp_q == AW'(DEPTH - 1)) ? '0 : rp_q + 1'b1;
      if (wr && !rd) cnt_q <= cnt_q + 1'b1;
      else if (rd && !wr) cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr) mem_q[wp_q] <= wdata_i;
  end

endmodule

@@ rtl/core/lrn_front.sv @@
// Front end of the LRN unit: takes samples, keeps the square and sample lines,
// forms the window sums and queues normalisation jobs. Uses lrn_pkg.
`timescale 1ns / 1ps

module lrn_front #(
  parameter int unsigned MAX_WINDOW = lrn_pkg::MaxWindowDefault
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  output logic              full_o,
  input  lrn_pkg::lrn_in_t  in_item_i,
  input  logic [3:0]        window_size_i,
  output lrn_pkg::lrn_job_t job_o,
  output logic              job_push_o,
  input  logic              job_full_i
);
  import lrn_pkg::*;

  localparam int unsigned RW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;

  lrn_front_e       state_q, state_d;
  logic [31:0]      sq_q  [MAX_WINDOW];
  logic [15:0]      smp_q [SampleDepth];
  logic [15:0]      seen_q;
  logic             last_q;
  logic [3:0]       n_q, n_eff;
  logic [2:0]       look_q, d;
  logic [3:0]       cnt_q;
  logic [SumW-1:0]  acc_q;
  logic [16:0]      mag;
  logic [33:0]      sq_full;
  logic [RW-1:0]    rd_idx;
  logic [31:0]      ring_rd;
  logic             accept, sum_done, emit_ok, step, done;

  always_comb begin
    n_eff = (window_size_i == 4'd0) ? 4'd1 : window_size_i;
    if (32'(n_eff) > MAX_WINDOW) n_eff = 4'(MAX_WINDOW);
  end

  assign mag     = in_item_i.sample[15] ? (17'h10000 - {1'b0, in_item_i.sample})
                                        : {1'b0, in_item_i.sample};
  assign sq_full = mag * mag;

  assign d       = look_q - cnt_q[2:0];
  assign rd_idx  = (state_q == F_SUM) ? RW'(cnt_q) : RW'(n_q - 4'd1 - cnt_q);
  assign ring_rd = sq_q[rd_idx];

  always_comb begin
    state_d    = state_q;
    accept     = 1'b0;
    sum_done   = 1'b0;
    step       = 1'b0;
    done       = 1'b0;
    job_push_o = 1'b0;
    full_o     = state_q != F_IDLE;
    if (cnt_q == 4'd0) emit_ok = seen_q > {13'd0, look_q};
    else               emit_ok = last_q && ({13'd0, d} < seen_q);
    case (state_q)
      F_IDLE: begin
        accept = push_i;
        if (push_i) state_d = F_SUM;
      end
      F_SUM: begin
        sum_done = cnt_q == n_q - 4'd1;
        if (sum_done) state_d = F_EMIT;
      end
      F_EMIT: begin
        // hold while a due job cannot enter the queue
        step       = !emit_ok || !job_full_i;
        job_push_o = emit_ok && !job_full_i;
        done       = step && (cnt_q[2:0] == look_q);
        if (done) state_d = F_IDLE;
      end
      default: state_d = F_IDLE;
    endcase
  end

  assign job_o.sample = smp_q[d];
  assign job_o.sum    = acc_q;
  assign job_o.last   = last_q && (cnt_q[2:0] == look_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
      seen_q  <= '0;
      last_q  <= 1'b0;
      n_q     <= 4'd1;
      look_q  <= '0;
      cnt_q   <= '0;
      acc_q   <= '0;
      for (int i = 0; i < MAX_WINDOW; i++) sq_q[i] <= '0;
    end else begin
      state_q <= state_d;
      if (accept) begin
        for (int i = MAX_WINDOW - 1; i > 0; i--) sq_q[i] <= sq_q[i-1];
        sq_q[0] <= sq_full[31:0];
        if (seen_q != 16'hFFFF) seen_q <= seen_q + 16'd1;
        last_q <= in_item_i.last_channel;
        n_q    <= n_eff;
        look_q <= n_eff[3:1];
        cnt_q  <= '0;
        acc_q  <= '0;
      end
      if (state_q == F_SUM) begin
        acc_q <= acc_q + SumW'(ring_rd);
        cnt_q <= sum_done ? 4'd0 : cnt_q + 4'd1;
      end
      if (step) begin
        // drop the outermost square for the next, narrower window
        acc_q <= acc_q - SumW'(ring_rd);
        cnt_q <= cnt_q + 4'd1;
        if (done && last_q) begin
          seen_q <= '0;
          for (int i = 0; i < MAX_WINDOW; i++) sq_q[i] <= '0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      for (int i = SampleDepth - 1; i > 0; i--) smp_q[i] <= smp_q[i-1];
      smp_q[0] <= in_item_i.sample;
    end
  end

endmodule

@@ rtl/core/lrn_back.sv @@
// Back end of the LRN unit: computes x * (1 + a*S)^-beta for one job at a time
// through log2 and exp2 iterations. Uses lrn_pkg.
`timescale 1ns / 1ps

module lrn_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  lrn_pkg::lrn_job_t job_i,
  input  logic              job_empty_i,
  output logic              job_pop_o,
  input  logic [23:0]       alpha_i,
  input  logic [15:0]       beta_i,
  output lrn_pkg::lrn_out_t res_o,
  output logic              res_push_o,
  input  logic              res_full_i
);
  import lrn_pkg::*;

  lrn_back_e    state_q, state_d;
  logic [15:0]  x_q;
  logic [SumW-1:0] sum_q;
  logic         last_q;
  logic [60:0]  z_q;
  logic [4:0]   pint_q;
  logic [30:0]  m_q;
  logic [15:0]  frac_q;
  logic [3:0]   cnt_q;
  logic [6:0]   ti_q;
  logic [15:0]  f_q;
  logic [30:0]  acc_q;
  logic [47:0]  prod_q;

  logic [41:0]  zlo, zhi;
  logic [61:0]  msq;
  logic [31:0]  m2;
  logic [36:0]  tprod;
  logic [RootW-1:0] root;
  logic [60:0]  eprod;
  logic [16:0]  mag;
  logic [47:0]  yprod;
  logic [7:0]   s;
  logic [48:0]  rnd, y;
  logic [15:0]  ysat;

  assign zlo   = alpha_i * sum_q[17:0];
  assign zhi   = alpha_i * sum_q[35:18];
  assign msq   = m_q * m_q;
  assign m2    = msq[61:30];
  assign tprod = beta_i * {pint_q, frac_q};
  assign root  = ExpRoots[cnt_q*RootW +: RootW];
  assign eprod = acc_q * root;
  assign mag   = x_q[15] ? (17'h10000 - {1'b0, x_q}) : {1'b0, x_q};
  assign yprod = mag * acc_q;

  // round to nearest and shift out the Q0.30 scale and the integer exponent
  always_comb begin
    s   = 8'd30 + {1'b0, ti_q};
    rnd = {1'b0, prod_q} + (49'd1 << (s - 8'd1));
    y   = (s > 8'd46) ? '0 : (rnd >> s);
    if (x_q[15]) begin
      ysat             = (y > 49'd32768) ? 16'h8000 : y[15:0];
      res_o.normalized = 16'(17'h10000 - {1'b0, ysat});
    end else begin
      ysat             = (y > 49'd32767) ? 16'h7FFF : y[15:0];
      res_o.normalized = ysat;
    end
    res_o.last_of_pixel = last_q;
  end

  always_comb begin
    state_d    = state_q;
    job_pop_o  = 1'b0;
    res_push_o = 1'b0;
    case (state_q)
      B_IDLE: begin
        job_pop_o = !job_empty_i;
        if (!job_empty_i) state_d = B_ZLO;
      end
      B_ZLO:  state_d = B_ZHI;
      B_ZHI:  state_d = B_NORM;
      B_NORM: if (z_q[60:41] == '0) state_d = B_LOG;
      B_LOG:  if (cnt_q == 4'd0) state_d = B_TMUL;
      B_TMUL: state_d = B_EXP;
      B_EXP:  if (cnt_q == 4'd15) state_d = B_YMUL;
      B_YMUL: state_d = B_OUT;
      B_OUT: begin
        res_push_o = !res_full_i;
        if (!res_full_i) state_d = B_IDLE;
      end
      default: state_d = B_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= B_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      case (state_q)
        B_NORM: cnt_q <= 4'd15;
        B_LOG:  cnt_q <= cnt_q - 4'd1;
        B_TMUL: cnt_q <= 4'd0;
        B_EXP:  cnt_q <= cnt_q + 4'd1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      B_IDLE: begin
        x_q    <= job_i.sample;
        sum_q  <= job_i.sum;
        last_q <= job_i.last;
      end
      B_ZLO: z_q <= (61'd1 << 40) + 61'(zlo);
      B_ZHI: begin
        z_q    <= z_q + 61'({zhi, 18'd0});
        pint_q <= '0;
      end
      B_NORM: begin
        // slide the leading one down to bit 40
        if (z_q[60:41] != '0) begin
          z_q    <= z_q >> 1;
          pint_q <= pint_q + 5'd1;
        end else begin
          m_q    <= z_q[40:10];
          frac_q <= '0;
        end
      end
      B_LOG: begin
        frac_q[cnt_q] <= m2[31];
        m_q           <= m2[31] ? m2[31:1] : m2[30:0];
      end
      B_TMUL: begin
        ti_q  <= tprod[36:30];
        f_q   <= tprod[29:14];
        acc_q <= 31'd1 << 30;
      end
      B_EXP: if (f_q[4'd15 - cnt_q]) acc_q <= eprod[60:30];
      B_YMUL: prod_q <= yprod;
      default: ;
    endcase
  end

endmodule

@@ rtl/core/cross_channel_lrn_unit.sv @@
// Top level of the cross-channel LRN unit: configuration registers, front end,
// job queue, back end and result queue. Uses lrn_pkg and the lrn_* modules.
//
// Usage: samples of one pixel enter in channel order on in_item_i with push;
// full high means the item is not taken. Flag the final channel with
// last_channel. Results leave in channel order on out_item_o while empty is
// low and are taken with pop; last_of_pixel marks the pixel's final result.
// The first result of a pixel appears once the look-ahead of window/2 further
// channels has arrived; the remaining ones follow the last channel.
// The front end takes no new sample until it has summed the window, one
// square per cycle, and emitted that sample's jobs. The back end works on
// one job at a time through its sequential leading-one search,
// 16-step log2 squaring loop and 16-step exp2 multiply loop; a two-entry job
// queue lets the front run ahead. When pop is held low the result queue
// fills, the back end waits, then the job queue fills and full stays high.
// Reset loads the register defaults and empties the square line and queues.
// Write configuration registers only while the unit is idle.
`timescale 1ns / 1ps

module cross_channel_lrn_unit #(
  parameter int unsigned MAX_WINDOW = lrn_pkg::MaxWindowDefault
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push,
  output logic              full,
  input  lrn_pkg::lrn_in_t  in_item_i,
  output logic              empty,
  input  logic              pop,
  output lrn_pkg::lrn_out_t out_item_o,
  input  logic              cfg_we_i,
  input  logic [1:0]        cfg_idx_i,
  input  logic [23:0]       cfg_data_i
);
  import lrn_pkg::*;

  logic [3:0]  window_q;
  logic [23:0] alpha_q;
  logic [15:0] beta_q;

  lrn_job_t job_in, job_out;
  logic     job_push, job_full, job_pop, job_empty;
  lrn_out_t res;
  logic     res_push, res_full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q <= 4'd5;
      alpha_q  <= 24'd335;
      beta_q   <= 16'd12288;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_WINDOW: window_q <= cfg_data_i[3:0];
        CFG_ALPHA:  alpha_q  <= cfg_data_i;
        CFG_BETA:   beta_q   <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  lrn_front #(.MAX_WINDOW(MAX_WINDOW)) u_front (
    .clk_i, .rst_ni,
    .push_i        (push),
    .full_o        (full),
    .in_item_i,
    .window_size_i (window_q),
    .job_o         (job_in),
    .job_push_o    (job_push),
    .job_full_i    (job_full)
  );

  lrn_fifo #(.WIDTH($bits(lrn_job_t)), .DEPTH(2)) u_job_q (
    .clk_i, .rst_ni,
    .push_i  (job_push),
    .full_o  (job_full),
    .wdata_i (job_in),
    .pop_i   (job_pop),
    .empty_o (job_empty),
    .rdata_o (job_out)
  );

  lrn_back u_back (
    .clk_i, .rst_ni,
    .job_i       (job_out),
    .job_empty_i (job_empty),
    .job_pop_o   (job_pop),
    .alpha_i     (alpha_q),
    .beta_i      (beta_q),
    .res_o       (res),
    .res_push_o  (res_push),
    .res_full_i  (res_full)
  );

  lrn_fifo #(.WIDTH($bits(lrn_out_t)), .DEPTH(2)) u_res_q (
    .clk_i, .rst_ni,
    .push_i  (res_push),
    .full_o  (res_full),
    .wdata_i (res),
    .pop_i   (pop),
    .empty_o (empty),
    .rdata_o (out_item_o)
  );

endmodule

@@ rtl/core/lrn_checker.sv @@
// Port-level checks for the cross-channel LRN unit, bound to the top level.
// Uses lrn_pkg.
`timescale 1ns / 1ps

module lrn_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              push,
  input logic              full,
  input logic              empty,
  input logic              pop,
  input lrn_pkg::lrn_out_t out_item_o
);

  // an accepted item leaves the front busy, so full is high after it
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !full) |=> full)
    else $error("full low right after an accepted item");

  a_full_needs_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(full) |-> $past(push))
    else $error("full rose without an item");

  a_result_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> !empty)
    else $error("waiting result withdrawn");

  a_result_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> $stable(out_item_o))
    else $error("waiting result changed");

endmodule

bind cross_channel_lrn_unit lrn_checker u_lrn_checker (.*);

@@ sim/tb_cross_channel_lrn_unit.sv @@
// Testbench for cross_channel_lrn_unit: drives pixels of channel samples through
// the queue ports, predicts each normalised result in a scoreboard class and checks it.
// Depends on lrn_pkg and the unit's RTL.
`timescale 1ns / 1ps

class lrn_scoreboard;
  localparam int MaxWin = 15;
  logic [3:0]  win_reg;
  logic [23:0] alpha_reg;
  logic [15:0] beta_reg;
  logic [31:0] sq_line [MaxWin];
  logic [15:0] smp_line [8];
  logic [35:0] last_sum;
  int unsigned seen;
  lrn_pkg::lrn_out_t awaited [$];
  int errors;

  function new();
    win_reg = 4'd5;
    alpha_reg = 24'd335;
    beta_reg = 16'd12288;
    foreach (sq_line[i]) sq_line[i] = '0;
    foreach (smp_line[i]) smp_line[i] = '0;
    last_sum = '0;
    seen = 0;
    errors = 0;
  endfunction

  function void set_reg(lrn_pkg::lrn_cfg_e idx, logic [23:0] val);
    case (idx)
      lrn_pkg::CFG_WINDOW: win_reg = val[3:0];
      lrn_pkg::CFG_ALPHA:  alpha_reg = val;
      lrn_pkg::CFG_BETA:   beta_reg = val[15:0];
      default: ;
    endcase
  endfunction

  function logic [63:0] int_sqrt(logic [63:0] v);
    logic [63:0] res, bt;
    res = '0;
    bt = 64'd1 << 62;
    while (bt > v) bt = bt >> 2;
    while (bt != 0) begin
      if (v >= res + bt) begin
        v = v - (res + bt);
        res = (res >> 1) + bt;
      end else begin
        res = res >> 1;
      end
      bt = bt >> 2;
    end
    return res;
  endfunction

  // log2 of a Q.40 value, Q.16 result
  function logic [31:0] log2_fix(logic [63:0] z);
    int unsigned p;
    logic [15:0] fr;
    logic [63:0] m;
    p = 40;
    fr = '0;
    while ((z >> p) > 1) p++;
    m = z >> (p - 30);
    for (int b = 15; b >= 0; b--) begin
      m = (m * m) >> 30;
      if (m >= (64'd1 << 31)) begin
        fr[b] = 1'b1;
        m = m >> 1;
      end
    end
    return ((p - 40) << 16) | 32'(fr);
  endfunction

  function logic [63:0] exp2_neg(logic [15:0] f);
    logic [63:0] acc, r;
    acc = 64'd1 << 30;
    r = 64'd1 << 29;
    for (int b = 15; b >= 0; b--) begin
      r = int_sqrt(r << 30);
      if (f[b]) acc = (acc * r) >> 30;
    end
    return acc;
  endfunction

  function logic [15:0] normalise(logic [15:0] x, logic [35:0] sum);
    logic [63:0] z, t, sh, mag, y;
    z = (64'd1 << 40) + 64'(alpha_reg) * 64'(sum);
    t = (64'(beta_reg) * 64'(log2_fix(z))) >> 14;
    sh = 30 + (t >> 16);
    mag = x[15] ? 64'(17'h10000 - x) : 64'(x);
    if (sh > 46) return '0;
    y = (mag * exp2_neg(t[15:0]) + (64'd1 << (sh - 1))) >> sh;
    if (x[15]) begin
      if (y > 32768) y = 32768;
      return 16'(17'h10000 - y);
    end
    if (y > 32767) y = 32767;
    return y[15:0];
  endfunction

  function void note_input(lrn_pkg::lrn_in_t it);
    int unsigned n, look, d;
    logic [15:0] x, mag;
    logic [63:0] sum;
    lrn_pkg::lrn_out_t r;
    int cnt;
    x = it.sample;
    cnt = 0;
    n = win_reg;
    if (n < 1) n = 1;
    if (n > MaxWin) n = MaxWin;
    look = n / 2;
    mag = x[15] ? 16'(17'h10000 - x) : x;
    for (int i = MaxWin - 1; i > 0; i--) sq_line[i] = sq_line[i-1];
    sq_line[0] = 32'(mag) * 32'(mag);
    for (int i = 7; i > 0; i--) smp_line[i] = smp_line[i-1];
    smp_line[0] = x;
    if (seen < 16'hFFFF) seen++;
    for (int unsigned k = 0; k <= look; k++) begin
      d = look - k;
      if (k == 0) begin
        if (seen <= look) continue;
      end else if (!it.last_channel || d >= seen) begin
        continue;
      end
      sum = '0;
      for (int unsigned i = 0; i + k < n; i++) sum += 64'(sq_line[i]);
      last_sum = sum[35:0];
      r.normalized = normalise(smp_line[d % 8], last_sum);
      r.last_of_pixel = 1'b0;
      awaited.push_back(r);
      cnt++;
    end
    if (it.last_channel) begin
      if (cnt > 0) awaited[awaited.size()-1].last_of_pixel = 1'b1;
      foreach (sq_line[i]) sq_line[i] = '0;
      seen = 0;
    end
  endfunction

  function void check_result(lrn_pkg::lrn_out_t got);
    lrn_pkg::lrn_out_t want;
    if (awaited.size() == 0) begin
      $display("%0t: unexpected item normalized=%0d last=%0b", $time,
               got.normalized, got.last_of_pixel);
      errors++;
      return;
    end
    want = awaited.pop_front();
    if (got.normalized !== want.normalized) begin
      $display("%0t: normalized expected %0d actual %0d", $time,
               want.normalized, got.normalized);
      errors++;
    end
    if (got.last_of_pixel !== want.last_of_pixel) begin
      $display("%0t: last_of_pixel expected %0b actual %0b", $time,
               want.last_of_pixel, got.last_of_pixel);
      errors++;
    end
  endfunction
endclass

module tb_cross_channel_lrn_unit;
  import lrn_pkg::*;

  localparam int DrainCycles = 250;
  localparam int IdleLimit = 4000;
  localparam int HoldCycles = 500;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic push = 1'b0;
  logic full;
  lrn_in_t in_item_i = '0;
  logic empty;
  logic pop = 1'b0;
  lrn_out_t out_item_o;
  logic cfg_we_i = 1'b0;
  logic [1:0] cfg_idx_i = '0;
  logic [23:0] cfg_data_i = '0;

  lrn_scoreboard sb = new();
  int sent = 0;
  int idle_cycles = 0;
  bit hold_done = 0;

  cross_channel_lrn_unit uut (
    .clk_i(clk_i), .rst_ni(rst_ni), .push(push), .full(full), .in_item_i(in_item_i),
    .empty(empty), .pop(pop), .out_item_o(out_item_o), .cfg_we_i(cfg_we_i),
    .cfg_idx_i(cfg_idx_i), .cfg_data_i(cfg_data_i)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  task automatic send_item(logic [15:0] x, bit last);
    lrn_in_t it;
    it.sample = x;
    it.last_channel = last;
    push <= 1'b1;
    in_item_i <= it;
    do @(posedge clk_i); while (full);
    sb.note_input(it);
    sent++;
    // burst ends now and then: drop push for a random gap
    if ($urandom_range(0, 5) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
  endtask

  task automatic send_pixel(int len);
    for (int c = 0; c < len; c++) send_item(16'($urandom), c == len - 1);
  endtask

  task automatic drain();
    push <= 1'b0;
    while (sb.awaited.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(lrn_cfg_e idx, logic [23:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    sb.set_reg(idx, val);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // receiver: check accepted items, stall on its own pattern, one long hold
  initial begin : receiver
    int hold;
    int mode;
    logic [15:0] pat;
    hold = 0;
    mode = 0;
    pat = 16'hA5C3;
    forever begin
      @(posedge clk_i);
      if (pop && !empty) sb.check_result(out_item_o);
      if (!hold_done && sent >= 60) begin
        hold_done = 1;
        hold = HoldCycles;
      end
      if ($urandom_range(0, 63) == 0) begin
        mode = $urandom_range(0, 2);
        pat = 16'($urandom);
      end
      if (hold > 0) begin
        hold--;
        pop <= 1'b0;
      end else begin
        pat = {pat[14:0], pat[15]};
        case (mode)
          0: pop <= 1'b1;
          1: pop <= pat[0];
          default: pop <= ($urandom_range(0, 3) != 0);
        endcase
      end
    end
  end

  initial begin : watchdog
    forever begin
      @(posedge clk_i);
      if ((push && !full) || (pop && !empty)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IdleLimit) begin
        $display("[cross_channel_lrn_unit] ERROR");
        $finish;
      end
    end
  end

  initial begin : stimulus
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // extremes at the reset settings
    send_item(16'h7FFF, 0);
    send_item(16'h8000, 0);
    send_item(16'h0000, 0);
    send_item(16'hFFFF, 0);
    send_item(16'h0100, 1);
    // short pixels
    send_item(16'h8000, 1);
    send_item(16'h7FFF, 0);
    send_item(16'h8001, 1);
    drain();

    // window zero acts as one; zero alpha and beta
    write_reg(CFG_WINDOW, 24'd0);
    write_reg(CFG_ALPHA, 24'd0);
    write_reg(CFG_BETA, 24'd0);
    send_item(16'h7FFF, 0);
    send_item(16'h8000, 1);
    drain();

    // widest window, huge exponent: result shifts out to zero
    write_reg(CFG_WINDOW, 24'd15);
    write_reg(CFG_ALPHA, 24'hFFFFFF);
    write_reg(CFG_BETA, 24'h00FFFF);
    for (int c = 0; c < 5; c++) send_item(c[0] ? 16'h8000 : 16'h7FFF, c == 4);
    drain();

    // window changed in the middle of a pixel
    write_reg(CFG_WINDOW, 24'd3);
    write_reg(CFG_BETA, 24'd12288);
    write_reg(CFG_ALPHA, 24'd40000);
    for (int c = 0; c < 4; c++) send_item(16'($urandom), 0);
    drain();
    write_reg(CFG_WINDOW, 24'd9);
    for (int c = 0; c < 3; c++) send_item(16'($urandom), c == 2);
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      int goal;
      write_reg(CFG_WINDOW, ph == 0 ? 24'hFFFFF1 : 24'($urandom));
      write_reg(CFG_ALPHA, ($urandom_range(0, 2) == 0) ? 24'($urandom)
                                                       : 24'($urandom_range(0, 4000)));
      write_reg(CFG_BETA, 24'($urandom));
      goal = sent + 40;
      while (sent < goal) send_pixel($urandom_range(0, 3) == 0 ? $urandom_range(1, 3)
                                                              : $urandom_range(4, 20));
      drain();
    end

    if (sb.errors == 0) begin
      $display("[cross_channel_lrn_unit] OK");
    end else begin
      $display("[cross_channel_lrn_unit] ERROR");
    end
    $finish;
  end
endmodule
